@@ hw/rtl/websocket_frame_deframer_unit_assert.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked after reset is released.
`define WFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("deframer assertion failed");
// Checked on every edge, reset included.
`define WFD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deframer assertion failed");
`else
`define WFD_ASSERT(lbl, clk, rstn, prop)
`define WFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/wfd_pkg.sv @@
// Types and constants for the WebSocket frame deframer.
`default_nettype none
package wfd_pkg;

  localparam int LengthBitsDef = 64;
  localparam int QueueDepthDef = 4;

  localparam logic [6:0] LenCodeExt16 = 7'd126;
  localparam logic [6:0] LenCodeExt64 = 7'd127;
  localparam logic [7:0] OpcodeMask   = 8'b0000_1111;
  localparam logic [7:0] LenCodeMask  = 8'b0111_1111;
  localparam logic [1:0] KeyLastIdx   = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_PAY
  } wfd_phase_t;

  // One queued result: payload byte and key byte are combined in the back end.
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] key;
    logic       has_data;
    logic       fin;
    logic [3:0] opcode;
    logic       last;
  } wfd_op_t;

endpackage
`default_nettype wire

@@ hw/rtl/wfd_ifs.sv @@
// Valid/ready stream interfaces for the deframer input and result channels.
`default_nettype none
interface wfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic       frame_fin;
  logic [3:0] frame_opcode;
  logic       last_of_frame;

  modport source (output valid, output data_byte, output has_data, output frame_fin,
                  output frame_opcode, output last_of_frame, input ready);
  modport sink (input valid, input data_byte, input has_data, input frame_fin,
                input frame_opcode, input last_of_frame, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/websocket_frame_deframer_unit.sv @@
// WebSocket frame deframer: parses frame headers and unmasks payload bytes.
// Throughput: one input beat per cycle, sustained; input ready drops only when
// the result queue (QUEUE_DEPTH entries) is full because the sink stalls.
// Each result is registered twice on its way out: written into the queue, then
// loaded into the output register.
// Reset: synchronous, active low; clears parser phase, queue and output valid.
`default_nettype none
module websocket_frame_deframer_unit
  import wfd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  wfd_in_if.sink    in_ch,
  wfd_out_if.source out_ch
);

  logic    q_push;
  wfd_op_t q_push_op;
  logic    q_pop;
  wfd_op_t q_pop_op;
  logic    q_full;
  logic    q_empty;

  wfd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .push    (q_push),
    .push_op (q_push_op)
  );

  wfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_op),
    .pop       (q_pop),
    .pop_data  (q_pop_op),
    .full      (q_full),
    .empty     (q_empty)
  );

  wfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_pop_op),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

@@ hw/rtl/wfd_front.sv @@
// Header parser: takes one beat per cycle while the queue is not full, and queues the results it causes.
`default_nettype none
`include "websocket_frame_deframer_unit_assert.svh"
module wfd_front
  import wfd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  wfd_in_if.sink    in_ch,
  input  wire logic q_full,
  output logic      push,
  output wfd_op_t   push_op
);

  wfd_phase_t             phase_r, phase_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [1:0]             kidx_r, kidx_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             opc_r, opc_nxt;
  logic                   mask_r, mask_nxt;
  logic                   long_r, long_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [7:0]             key_r [4];
  logic [7:0]             key_nxt [4];

  logic                   acc;
  logic [7:0]             b;
  logic [6:0]             code;
  logic                   code_ext;
  logic [LENGTH_BITS-1:0] ext_val;
  logic                   ext_done;
  logic                   rem_is_one;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;
  assign code        = 7'(b & LenCodeMask);
  assign code_ext    = (code == LenCodeExt16) || (code == LenCodeExt64);
  assign rem_is_one  = (rem_r == LENGTH_BITS'(1));
  assign ext_done    = long_r ? (cnt_r == 3'd7) : (cnt_r == 3'd1);

  // saturate once the top byte is occupied
  assign ext_val = (rem_r[LENGTH_BITS-1 -: 8] != 8'd0) ? '1
                                                      : {rem_r[LENGTH_BITS-9:0], b};

  // next state and parser registers
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    kidx_nxt  = kidx_r;
    fin_nxt   = fin_r;
    opc_nxt   = opc_r;
    mask_nxt  = mask_r;
    long_nxt  = long_r;
    rem_nxt   = rem_r;
    key_nxt   = key_r;
    if (acc) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt   = b[7];
          opc_nxt   = 4'(b & OpcodeMask);
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          mask_nxt = b[7];
          cnt_nxt  = 3'd0;
          if (code_ext) begin
            long_nxt  = (code == LenCodeExt64);
            rem_nxt   = '0;
            phase_nxt = PH_EXT;
          end else begin
            rem_nxt = LENGTH_BITS'(code);
            if (b[7]) begin
              phase_nxt = PH_KEY;
            end else begin
              kidx_nxt  = 2'd0;
              phase_nxt = (code == 7'd0) ? PH_HDR0 : PH_PAY;
            end
          end
        end
        PH_EXT: begin
          rem_nxt = ext_val;
          if (ext_done) begin
            cnt_nxt = 3'd0;
            if (mask_r) begin
              phase_nxt = PH_KEY;
            end else begin
              kidx_nxt  = 2'd0;
              phase_nxt = (ext_val == '0) ? PH_HDR0 : PH_PAY;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_KEY: begin
          key_nxt[cnt_r[1:0]] = b;
          if (cnt_r[1:0] == KeyLastIdx) begin
            cnt_nxt   = 3'd0;
            kidx_nxt  = 2'd0;
            phase_nxt = (rem_r == '0) ? PH_HDR0 : PH_PAY;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_PAY: begin
          kidx_nxt = kidx_r + 2'd1;
          rem_nxt  = rem_r - LENGTH_BITS'(1);
          if (rem_is_one) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: phase_nxt = PH_HDR0;
      endcase
    end
  end

  // queued results
  always_comb begin
    push             = 1'b0;
    push_op.raw      = b;
    push_op.key      = mask_r ? key_r[kidx_r] : 8'd0;
    push_op.has_data = 1'b1;
    push_op.fin      = fin_r;
    push_op.opcode   = opc_r;
    push_op.last     = rem_is_one;
    if (acc) begin
      unique case (phase_r)
        PH_HDR0: push = 1'b0;
        PH_HDR1: push = !code_ext && !b[7] && (code == 7'd0);
        PH_EXT:  push = ext_done && !mask_r && (ext_val == '0);
        PH_KEY:  push = (cnt_r[1:0] == KeyLastIdx) && (rem_r == '0);
        PH_PAY:  push = 1'b1;
        default: push = 1'b0;
      endcase
      // empty-frame marker
      if (phase_r != PH_PAY) begin
        push_op.raw      = 8'd0;
        push_op.key      = 8'd0;
        push_op.has_data = 1'b0;
        push_op.last     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      cnt_r   <= 3'd0;
      kidx_r  <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r  <= fin_nxt;
    opc_r  <= opc_nxt;
    mask_r <= mask_nxt;
    long_r <= long_nxt;
    rem_r  <= rem_nxt;
    key_r  <= key_nxt;
  end

  `WFD_ASSERT(a_pay_len_nonzero, clk, rst_n, (phase_r == PH_PAY) |-> (rem_r != '0))
  `WFD_ASSERT(a_marker_is_last, clk, rst_n, (push && !push_op.has_data) |-> push_op.last)
  `WFD_ASSERT(a_push_needs_room, clk, rst_n, push |-> !q_full)

endmodule
`default_nettype wire

@@ hw/rtl/wfd_queue.sv @@
// Short result queue between the parser and the output stage.
`default_nettype none
`include "websocket_frame_deframer_unit_assert.svh"
module wfd_queue
  import wfd_pkg::*;
#(
  parameter int DEPTH = QueueDepthDef
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire wfd_op_t push_data,
  input  wire logic    pop,
  output wfd_op_t      pop_data,
  output logic         full,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wfd_op_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `WFD_ASSERT(a_no_underflow, clk, rst_n, pop |-> !empty)
  `WFD_ASSERT(a_count_grows, clk, rst_n, (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))

endmodule
`default_nettype wire

@@ hw/rtl/wfd_back.sv @@
// Output stage: unmasks queued beats into a registered result channel.
`default_nettype none
`include "websocket_frame_deframer_unit_assert.svh"
module wfd_back
  import wfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_empty,
  input  wire wfd_op_t q_data,
  output logic         q_pop,
  wfd_out_if.source    out_ch
);

  logic       vld_r;
  logic [7:0] data_r;
  logic       has_r;
  logic       fin_r;
  logic [3:0] opc_r;
  logic       last_r;

  assign q_pop = !q_empty && (!vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || out_ch.ready) begin
      vld_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_data.raw ^ q_data.key;
      has_r  <= q_data.has_data;
      fin_r  <= q_data.fin;
      opc_r  <= q_data.opcode;
      last_r <= q_data.last;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.data_byte     = data_r;
  assign out_ch.has_data      = has_r;
  assign out_ch.frame_fin     = fin_r;
  assign out_ch.frame_opcode  = opc_r;
  assign out_ch.last_of_frame = last_r;

  `WFD_ASSERT(a_pop_loads_output, clk, rst_n, q_pop |=> vld_r)
  `WFD_ASSERT_ALWAYS(a_reset_clears_valid, clk, !rst_n |=> !vld_r)

endmodule
`default_nettype wire
